// ===== src/stft_pkg.sv =====
`timescale 1ns / 1ps

package stft_pkg;

  // Longest line kept; characters at this column and beyond are dropped.
  localparam int LINE_LEN = 256;

  // The column counter must be able to hold LINE_LEN itself.
  localparam int COL_W = $clog2(LINE_LEN + 1);

  // Working width for column arithmetic, never below the 9-bit length field.
  localparam int AW = (COL_W > 9) ? COL_W : 9;

  // Entries in the queue between the tokenizer and the classifier.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  typedef enum logic [2:0] {
    KIND_ALNUM = 3'd0,
    KIND_ALPHA = 3'd1,
    KIND_INT   = 3'd2,
    KIND_DEC   = 3'd3,
    KIND_LABEL = 3'd4,
    KIND_BAD   = 3'd5
  } field_kind_e;

  // What the last character of a run says about the field.
  typedef enum logic [2:0] {
    LC_ALPHA,
    LC_ALNUM,
    LC_NUM,
    LC_POINT,
    LC_LABEL
  } last_class_e;

  // One closed run, as handed from the tokenizer to the classifier.
  typedef struct packed {
    logic [15:0]      field_number;
    logic [15:0]      line_index;
    logic [COL_W-1:0] start_col;
    logic [COL_W-1:0] end_col;
    logic [COL_W-1:0] point_col;
    last_class_e      last_class;
    logic             first_sign;
    logic             first_point;
    logic             other_seen;
    logic [1:0]       sign_cnt;
    logic [1:0]       point_cnt;
    logic             overflowed;
  } field_event_t;

endpackage

// ===== src/stft_front.sv =====
`timescale 1ns / 1ps

module stft_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            character_i,
  input  logic                  line_end_i,
  output logic                  push_o,
  output stft_pkg::field_event_t event_o
);

  logic [stft_pkg::COL_W-1:0] column_q, column_d;
  logic [15:0]                line_q, line_d;
  logic [15:0]                field_q, field_d;
  logic                       in_run_q, in_run_d;
  logic                       ovf_q, ovf_d;
  logic [stft_pkg::COL_W-1:0] start_q, start_d;
  logic [stft_pkg::COL_W-1:0] point_col_q, point_col_d;
  stft_pkg::last_class_e      last_q, last_d;
  logic                       first_sign_q, first_sign_d;
  logic                       first_point_q, first_point_d;
  logic                       other_q, other_d;
  logic [1:0]                 sign_cnt_q, sign_cnt_d;
  logic [1:0]                 point_cnt_q, point_cnt_d;

  logic                       at_limit;
  logic                       is_space;
  logic                       emit;
  logic [15:0]                field_inc;

  function automatic stft_pkg::last_class_e classify(input logic [7:0] ch);
    stft_pkg::last_class_e c;
    if (ch == stft_pkg::CH_HASH) begin
      c = stft_pkg::LC_ALPHA;
    end else if (ch == stft_pkg::CH_STAR) begin
      c = stft_pkg::LC_ALNUM;
    end else if (ch == stft_pkg::CH_POINT) begin
      c = stft_pkg::LC_POINT;
    end else if (ch == stft_pkg::CH_NINE || ch == stft_pkg::CH_PLUS ||
                 ch == stft_pkg::CH_MINUS) begin
      c = stft_pkg::LC_NUM;
    end else begin
      c = stft_pkg::LC_LABEL;
    end
    return c;
  endfunction

  always_comb begin
    at_limit = (column_q == stft_pkg::COL_W'(stft_pkg::LINE_LEN));
    is_space = (character_i == stft_pkg::CH_SPACE);

    start_d       = start_q;
    point_col_d   = point_col_q;
    last_d        = last_q;
    first_sign_d  = first_sign_q;
    first_point_d = first_point_q;
    other_d       = other_q;
    sign_cnt_d    = sign_cnt_q;
    point_cnt_d   = point_cnt_q;

    // A kept non-space character opens a run if needed and is absorbed.
    if (!at_limit && !is_space) begin
      if (!in_run_q) begin
        start_d       = column_q;
        first_sign_d  = (character_i == stft_pkg::CH_PLUS) ||
                        (character_i == stft_pkg::CH_MINUS);
        first_point_d = (character_i == stft_pkg::CH_POINT);
        other_d       = 1'b0;
        sign_cnt_d    = 2'd0;
        point_cnt_d   = 2'd0;
        point_col_d   = '0;
      end
      if (character_i >= stft_pkg::CH_ZERO && character_i <= stft_pkg::CH_NINE) begin
        other_d = other_d;
      end else if (character_i == stft_pkg::CH_PLUS ||
                   character_i == stft_pkg::CH_MINUS) begin
        if (sign_cnt_d != 2'd2) begin
          sign_cnt_d = sign_cnt_d + 2'd1;
        end
      end else if (character_i == stft_pkg::CH_POINT) begin
        if (point_cnt_d != 2'd2) begin
          point_cnt_d = point_cnt_d + 2'd1;
        end
        point_col_d = column_q;
      end else begin
        other_d = 1'b1;
      end
      last_d = classify(character_i);
    end

    // Which case closes a run, and where it ends.
    priority if (at_limit) begin
      emit = line_end_i && in_run_q;
      event_o.end_col = column_q - stft_pkg::COL_W'(1);
    end else if (is_space) begin
      emit = in_run_q;
      event_o.end_col = column_q - stft_pkg::COL_W'(1);
    end else begin
      emit = line_end_i;
      event_o.end_col = column_q;
    end

    field_inc = (field_q == 16'hFFFF) ? field_q : field_q + 16'd1;

    event_o.field_number = field_inc;
    event_o.line_index   = line_q;
    event_o.start_col    = start_d;
    event_o.point_col    = point_col_d;
    event_o.last_class   = last_d;
    event_o.first_sign   = first_sign_d;
    event_o.first_point  = first_point_d;
    event_o.other_seen   = other_d;
    event_o.sign_cnt     = sign_cnt_d;
    event_o.point_cnt    = point_cnt_d;
    event_o.overflowed   = ovf_q || at_limit;

    push_o  = accept_i && emit;
    field_d = emit ? field_inc : field_q;

    if (line_end_i) begin
      column_d = '0;
      in_run_d = 1'b0;
      ovf_d    = 1'b0;
      line_d   = line_q + 16'd1;
    end else begin
      column_d = at_limit ? column_q : column_q + stft_pkg::COL_W'(1);
      in_run_d = at_limit ? in_run_q : !is_space;
      ovf_d    = ovf_q || at_limit;
      line_d   = line_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q      <= '0;
      line_q        <= '0;
      field_q       <= '0;
      in_run_q      <= 1'b0;
      ovf_q         <= 1'b0;
      start_q       <= '0;
      point_col_q   <= '0;
      last_q        <= stft_pkg::LC_LABEL;
      first_sign_q  <= 1'b0;
      first_point_q <= 1'b0;
      other_q       <= 1'b0;
      sign_cnt_q    <= 2'd0;
      point_cnt_q   <= 2'd0;
    end else if (accept_i) begin
      column_q      <= column_d;
      line_q        <= line_d;
      field_q       <= field_d;
      in_run_q      <= in_run_d;
      ovf_q         <= ovf_d;
      start_q       <= start_d;
      point_col_q   <= point_col_d;
      last_q        <= last_d;
      first_sign_q  <= first_sign_d;
      first_point_q <= first_point_d;
      other_q       <= other_d;
      sign_cnt_q    <= sign_cnt_d;
      point_cnt_q   <= point_cnt_d;
    end
  end

endmodule

// ===== src/stft_fifo.sv =====
`timescale 1ns / 1ps

module stft_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  stft_pkg::field_event_t data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output stft_pkg::field_event_t data_o
);

  stft_pkg::field_event_t       mem_q [stft_pkg::QDEPTH];
  logic [stft_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [stft_pkg::QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [stft_pkg::QCNT_W-1:0]  count_q, count_d;
  logic                         do_push;
  logic                         do_pop;

  function automatic logic [stft_pkg::QPTR_W-1:0] next_ptr(
    input logic [stft_pkg::QPTR_W-1:0] p
  );
    logic [stft_pkg::QPTR_W-1:0] n;
    if (p == stft_pkg::QPTR_W'(stft_pkg::QDEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + stft_pkg::QPTR_W'(1);
    end
    return n;
  endfunction

  always_comb begin
    full_o   = (count_q == stft_pkg::QCNT_W'(stft_pkg::QDEPTH));
    valid_o  = (count_q != '0);
    data_o   = mem_q[rd_ptr_q];
    do_push  = push_i && !full_o;
    do_pop   = pop_i && valid_o;
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + stft_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - stft_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/stft_back.sv =====
`timescale 1ns / 1ps

module stft_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  stft_pkg::field_event_t event_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [15:0]            field_number_o,
  output logic [15:0]            line_index_o,
  output logic [7:0]             start_column_o,
  output logic [7:0]             end_column_o,
  output logic [8:0]             field_length_o,
  output logic [2:0]             field_kind_o,
  output logic                   number_signed_o,
  output logic [7:0]             decimal_places_o,
  output logic                   overflowed_o
);

  logic                   valid_q, valid_d;
  logic [15:0]            field_number_q;
  logic [15:0]            line_index_q;
  logic [7:0]             start_q;
  logic [7:0]             end_q;
  logic [8:0]             length_q;
  stft_pkg::field_kind_e  kind_q, kind_d;
  logic                   signed_q, signed_d;
  logic [7:0]             dec_q;
  logic                   ovf_q;

  logic [stft_pkg::AW-1:0]    start_w;
  logic [stft_pkg::AW-1:0]    end_w;
  logic [stft_pkg::AW-1:0]    length_w;
  logic [stft_pkg::COL_W-1:0] dec_d;
  logic                       bad;

  always_comb begin
    start_w  = stft_pkg::AW'(event_i.start_col);
    end_w    = stft_pkg::AW'(event_i.end_col);
    length_w = end_w - start_w + stft_pkg::AW'(1);

    bad = event_i.other_seen || (event_i.sign_cnt == 2'd2) ||
          (event_i.sign_cnt == 2'd1 && !event_i.first_sign) ||
          (event_i.point_cnt == 2'd2) ||
          (event_i.point_cnt == 2'd1 &&
           (event_i.first_point || event_i.last_class == stft_pkg::LC_POINT));

    dec_d    = '0;
    signed_d = 1'b0;
    unique case (event_i.last_class)
      stft_pkg::LC_ALPHA: kind_d = stft_pkg::KIND_ALPHA;
      stft_pkg::LC_ALNUM: kind_d = stft_pkg::KIND_ALNUM;
      stft_pkg::LC_NUM, stft_pkg::LC_POINT: begin
        if (bad) begin
          kind_d = stft_pkg::KIND_BAD;
        end else begin
          signed_d = (event_i.sign_cnt == 2'd1);
          if (event_i.point_cnt == 2'd1) begin
            dec_d = event_i.end_col - event_i.point_col;
          end
          kind_d = (dec_d != '0) ? stft_pkg::KIND_DEC : stft_pkg::KIND_INT;
        end
      end
      default: kind_d = stft_pkg::KIND_LABEL;
    endcase

    pop_o   = valid_i && (!valid_q || !out_stall_i);
    valid_d = pop_o || (valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      field_number_q <= event_i.field_number;
      line_index_q   <= event_i.line_index;
      start_q        <= start_w[7:0];
      end_q          <= end_w[7:0];
      length_q       <= length_w[8:0];
      kind_q         <= kind_d;
      signed_q       <= signed_d;
      dec_q          <= 8'(stft_pkg::AW'(dec_d));
      ovf_q          <= event_i.overflowed;
    end
  end

  assign out_valid_o      = valid_q;
  assign field_number_o   = field_number_q;
  assign line_index_o     = line_index_q;
  assign start_column_o   = start_q;
  assign end_column_o     = end_q;
  assign field_length_o   = length_q;
  assign field_kind_o     = kind_q;
  assign number_signed_o  = signed_q;
  assign decimal_places_o = dec_q;
  assign overflowed_o     = ovf_q;

endmodule

// ===== src/screen_template_field_tokenizer.sv =====
// Screen-template field tokenizer. Template text enters one character per word with
// line_end_i high on the last character of each line; every run of non-space characters
// comes out as one field descriptor word (field number, line, start and end column,
// length, kind, sign, decimal places, overflow) when a space or the line end closes it.
// The kind follows the run's last character: '#' alphabetic, '*' alphanumeric,
// '9' '.' '+' '-' numeric (checked and reported as integer, decimal or malformed),
// anything else label. Characters at column LINE_LEN and beyond are dropped and flag
// the field still open on that line. The block takes one character every cycle unless
// in_stall_o is high: the tokenizer updates its run state per character, a two-word
// queue feeds the classifier, and an output register holds the finished descriptor, so
// in_stall_o rises only when that queue is full because out_stall_i has held results
// back. A closed field's descriptor passes through the queue, then the output register.
`timescale 1ns / 1ps

module screen_template_field_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  character_i,
  input  logic        line_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] field_number_o,
  output logic [15:0] line_index_o,
  output logic [7:0]  start_column_o,
  output logic [7:0]  end_column_o,
  output logic [8:0]  field_length_o,
  output logic [2:0]  field_kind_o,
  output logic        number_signed_o,
  output logic [7:0]  decimal_places_o,
  output logic        overflowed_o
);

  // A character is taken whenever the queue has room, since it may close a field.
  logic                   accept;
  logic                   push;
  logic                   q_full;
  logic                   q_valid;
  logic                   pop;
  stft_pkg::field_event_t ev_in;
  stft_pkg::field_event_t ev_out;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // Front end: run tracking, column and line counting, field numbering.
  stft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .character_i (character_i),
    .line_end_i  (line_end_i),
    .push_o      (push),
    .event_o     (ev_in)
  );

  // Short queue that lets the front end keep going while the output is stalled.
  stft_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (ev_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (ev_out)
  );

  // Back end: number layout check, kind, length, and the output register.
  stft_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (q_valid),
    .event_i          (ev_out),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .field_number_o   (field_number_o),
    .line_index_o     (line_index_o),
    .start_column_o   (start_column_o),
    .end_column_o     (end_column_o),
    .field_length_o   (field_length_o),
    .field_kind_o     (field_kind_o),
    .number_signed_o  (number_signed_o),
    .decimal_places_o (decimal_places_o),
    .overflowed_o     (overflowed_o)
  );

endmodule
